>>> sv/panorama_to_fisheye_coord_map_unit_assert.svh
// Assertion macros for the panorama to fisheye coordinate map.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PANORAMA_TO_FISHEYE_COORD_MAP_UNIT_ASSERT_SVH
`define PANORAMA_TO_FISHEYE_COORD_MAP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define P2F_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("p2f check failed");
// next-cycle implication
`define P2F_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("p2f check failed");
`else
`define P2F_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define P2F_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/p2f_pkg.sv
// Shared constants, types and helper functions for the panorama to fisheye map.
// No dependencies; used by every module of the block.
`default_nettype none

package p2f_pkg;

    localparam int COORD_BITS      = 12;
    localparam int CORDIC_STAGES   = 18;
    localparam int ANGLE_FRAC_BITS = 20;

    // cells per CORDIC lane and shift index width
    localparam int NCELL = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
    localparam int SH_W  = $clog2(NCELL);

    // angle formats: Q4.F and one guard bit for the CORDIC angle path
    localparam int A_W  = ANGLE_FRAC_BITS + 4;
    localparam int Z_W  = A_W + 1;
    localparam int ZE_W = Z_W + 1;

    // datapath widths
    localparam int XY_W   = 37;
    localparam int T_W    = 33;
    localparam int SIDE_W = XY_W + 1;
    localparam int CFG_W  = 48;
    localparam int CFG_IDX_W = 3;

    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint PI_Q32      = 64'sd13493037705;
    localparam longint HALF_PI_Q32 = 64'sd6746518852;

    localparam longint ATAN_Q32 [24] = '{
        64'sd3373259426, 64'sd1991351318, 64'sd1052175346, 64'sd534100635,
        64'sd268086748,  64'sd134174063,  64'sd67103403,   64'sd33553749,
        64'sd16777131,   64'sd8388597,    64'sd4194303,    64'sd2097152,
        64'sd1048576,    64'sd524288,     64'sd262144,     64'sd131072,
        64'sd65536,      64'sd32768,      64'sd16384,      64'sd8192,
        64'sd4096,       64'sd2048,       64'sd1024,       64'sd512
    };

    // round a Q.32 constant to the angle format
    function automatic longint q32_to_angle(input longint v);
        q32_to_angle = (v + (64'sd1 <<< (31 - ANGLE_FRAC_BITS))) >>> (32 - ANGLE_FRAC_BITS);
    endfunction

    localparam longint PI_A   = q32_to_angle(PI_Q32);
    localparam longint HALF_A = q32_to_angle(HALF_PI_Q32);

    // arctangent of 2^-i in angle format
    function automatic logic signed [Z_W-1:0] atan_ang(input int i);
        atan_ang = Z_W'(q32_to_angle(ATAN_Q32[i]));
    endfunction

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_B    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_C    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PANO_SZ  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PANO_RPP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_SZ   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_PPR  = 3'd6;

    // CORDIC cell modes
    localparam logic MODE_ROT = 1'b0;
    localparam logic MODE_VEC = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] pano_x;
        logic [COORD_BITS-1:0] pano_y;
    } t_in_word;

    typedef struct packed {
        logic [COORD_BITS-1:0] src_x;
        logic [COORD_BITS-1:0] src_y;
        logic                  in_bounds;
    } t_out_word;

    // state handed from one CORDIC cell to the next
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [SIDE_W-1:0]      side;
    } t_cord;

endpackage

`default_nettype wire

>>> sv/panorama_to_fisheye_coord_map_unit.sv
// Top level: maps a panorama pixel to a fisheye source pixel through CORDIC lanes.
// Depends on p2f_pkg, p2f_cordic_chain and the assertion macro header.
//
//   channel | direction | handshake                  | word
//   input   | in        | i_in_valid / o_in_stall    | i_in_word  (pano_x, pano_y)
//   output  | out       | o_out_valid / i_out_stall  | o_out_word (src_x, src_y, in_bounds)
//   config  | in        | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One word per cycle while i_out_stall is low.
// Throughput is set by the fully pipelined CORDIC lanes, one cell per step.
// Every stage holds a valid bit; a stage loads when it is empty or its successor loads,
// so bubbles collapse and new words enter while a finished word waits at the output.
// Reset (synchronous, active low) clears the valid bits and restores the configuration registers.
`default_nettype none

`include "panorama_to_fisheye_coord_map_unit_assert.svh"

module panorama_to_fisheye_coord_map_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire p2f_pkg::t_in_word                i_in_word,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output p2f_pkg::t_out_word                    o_out_word,
    input  wire logic                             i_cfg_we,
    input  wire logic [p2f_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [p2f_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int NC   = p2f_pkg::NCELL;
    localparam int CB   = p2f_pkg::COORD_BITS;
    localparam int AFB  = p2f_pkg::ANGLE_FRAC_BITS;
    localparam int A_W  = p2f_pkg::A_W;
    localparam int Z_W  = p2f_pkg::Z_W;
    localparam int ZE_W = p2f_pkg::ZE_W;
    localparam int XY_W = p2f_pkg::XY_W;
    localparam int T_W  = p2f_pkg::T_W;
    localparam int SIDE_W = p2f_pkg::SIDE_W;

    localparam int C_W    = 15;
    localparam int PRD_W  = C_W + 25;
    localparam int TA_W   = PRD_W + 6;
    localparam int TA_SH  = 22 - AFB;
    localparam int PM_W   = 2 * T_W;
    localparam int MP_W   = 16 + T_W;
    localparam int MS_W   = MP_W + 2;
    localparam int MG_W   = XY_W - 8 + 31;
    localparam int RP_W   = 25 + Z_W;
    localparam int RHO_W  = 29;
    localparam int DP_W   = RHO_W + T_W;
    localparam int SX_W   = 34;

    // stage positions
    localparam int P_CTR  = 0;
    localparam int P_MUL  = 1;
    localparam int P_ANG  = 2;
    localparam int P_PRE1 = 3;
    localparam int P_C1   = 4;
    localparam int P_TRIG = P_C1 + NC;
    localparam int P_VMUL = P_TRIG + 1;
    localparam int P_VEC  = P_VMUL + 1;
    localparam int P_MMUL = P_VEC + 1;
    localparam int P_W    = P_MMUL + 1;
    localparam int P_PRE2 = P_W + 1;
    localparam int P_C2   = P_PRE2 + 1;
    localparam int P_MAG1 = P_C2 + NC;
    localparam int P_MAG2 = P_MAG1 + 1;
    localparam int P_PRE3 = P_MAG2 + 1;
    localparam int P_C3   = P_PRE3 + 1;
    localparam int P_RHO  = P_C3 + NC;
    localparam int P_RHOS = P_RHO + 1;
    localparam int P_DMUL = P_RHOS + 1;
    localparam int P_D    = P_DMUL + 1;
    localparam int P_OUT  = P_D + 1;
    localparam int NSTG   = P_OUT + 1;

    localparam logic signed [ZE_W-1:0] PI_E   = ZE_W'(p2f_pkg::PI_A);
    localparam logic signed [ZE_W-1:0] PI2_E  = ZE_W'(2 * p2f_pkg::PI_A);
    localparam logic signed [ZE_W-1:0] HALF_E = ZE_W'(p2f_pkg::HALF_A);
    localparam logic signed [Z_W-1:0]  HALF_Z = Z_W'(p2f_pkg::HALF_A);
    localparam logic signed [TA_W-1:0] HALF_T = TA_W'(p2f_pkg::HALF_A);
    localparam logic signed [TA_W-1:0] ANG_HI = $signed(TA_W'(1) <<< (A_W - 1)) - 1;
    localparam logic signed [TA_W-1:0] ANG_LO = -$signed(TA_W'(1) <<< (A_W - 1));

    // saturate to the Q4 angle range
    function automatic logic signed [A_W-1:0] sat_ang(input logic signed [TA_W-1:0] v);
        if (v > ANG_HI) begin
            sat_ang = A_W'(ANG_HI);
        end else if (v < ANG_LO) begin
            sat_ang = A_W'(ANG_LO);
        end else begin
            sat_ang = A_W'(v);
        end
    endfunction

    // reduce to the right half plane for sine/cosine rotation
    function automatic p2f_pkg::t_cord sc_prep(input logic signed [Z_W-1:0] a_in,
                                              input logic tag);
        logic signed [ZE_W-1:0] a;
        logic                   flip;
        p2f_pkg::t_cord         c;
        a    = ZE_W'(a_in);
        flip = 1'b0;
        if (a > PI_E) begin
            a = a - PI2_E;
        end else if (a < -PI_E) begin
            a = a + PI2_E;
        end
        if (a > HALF_E) begin
            a    = PI_E - a;
            flip = 1'b1;
        end else if (a < -HALF_E) begin
            a    = -PI_E - a;
            flip = 1'b1;
        end
        c.x    = XY_W'(p2f_pkg::GAIN_Q30);
        c.y    = '0;
        c.z    = Z_W'(a);
        c.side = SIDE_W'({tag, flip});
        sc_prep = c;
    endfunction

    // turn a left half plane vector into the right half plane
    function automatic p2f_pkg::t_cord vec_prep(input logic signed [XY_W-1:0] x,
                                               input logic signed [XY_W-1:0] y,
                                               input logic [SIDE_W-1:0] sd);
        p2f_pkg::t_cord c;
        c.side = sd;
        if (x < 0) begin
            if (y >= 0) begin
                c.x = y;
                c.y = -x;
                c.z = HALF_Z;
            end else begin
                c.x = -y;
                c.y = x;
                c.z = -HALF_Z;
            end
        end else begin
            c.x = x;
            c.y = y;
            c.z = '0;
        end
        vec_prep = c;
    endfunction

    // configuration registers
    logic [47:0] r_rot [3];
    logic [25:0] r_pano_size;
    logic [23:0] r_rpp;
    logic [25:0] r_src_size;
    logic [23:0] r_sppr;

    // pipeline control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG:0]   w_rdy;

    // stage registers
    logic signed [C_W-1:0]   r_cx, r_cy;
    logic signed [C_W-1:0]   w_kx, w_ky;
    logic signed [PRD_W-1:0] r_px_prd, r_py_prd;
    logic signed [TA_W-1:0]  w_xe, w_ye, w_tax, w_tay;
    logic signed [A_W-1:0]   r_phi, r_theta;
    p2f_pkg::t_cord          r_c1t, r_c1p, w_o1t, w_o1p;
    logic signed [T_W-1:0]   r_st, r_ct, r_sp, r_cp, r_ct2;
    logic signed [PM_W-1:0]  r_psp, r_pcp;
    logic signed [T_W-1:0]   r_v [3];
    logic signed [MP_W-1:0]  r_mp [3][3];
    logic signed [MS_W-1:0]  w_wsum [3];
    logic signed [XY_W-1:0]  r_w [3];
    logic                    w_nz;
    p2f_pkg::t_cord          r_c2, w_o2;
    logic signed [MG_W-1:0]  r_mg_prd;
    logic signed [Z_W-1:0]   r_psi1, r_psi2;
    logic [SIDE_W-1:0]       r_sd1, r_sd2;
    logic signed [XY_W-1:0]  r_r;
    p2f_pkg::t_cord          r_c3v, r_c3s, w_o3v, w_o3s;
    logic signed [RP_W-1:0]  r_rho_prd;
    logic signed [T_W-1:0]   r_c, r_s;
    logic                    r_nz3, r_nz4, r_nz5;
    logic signed [RHO_W-1:0] r_rho;
    logic signed [T_W-1:0]   r_c2b, r_s2b;
    logic signed [DP_W-1:0]  r_dxp, r_dyp;
    logic signed [DP_W-31:0] w_dx, w_dy;
    logic signed [SX_W-1:0]  r_sx, r_sy;
    logic                    w_ok;
    logic                    w_out_zero;
    p2f_pkg::t_out_word      r_out;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0]    <= 48'd70368744177664;
            r_rot[1]    <= 48'd1073741824;
            r_rot[2]    <= 48'd16384;
            r_pano_size <= 26'd4195328;
            r_rpp       <= 24'd25736;
            r_src_size  <= 26'd8389632;
            r_sppr      <= 24'd1335088;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                p2f_pkg::CFG_ROW_A:    r_rot[0]    <= i_cfg_data[47:0];
                p2f_pkg::CFG_ROW_B:    r_rot[1]    <= i_cfg_data[47:0];
                p2f_pkg::CFG_ROW_C:    r_rot[2]    <= i_cfg_data[47:0];
                p2f_pkg::CFG_PANO_SZ:  r_pano_size <= i_cfg_data[25:0];
                p2f_pkg::CFG_PANO_RPP: r_rpp       <= i_cfg_data[23:0];
                p2f_pkg::CFG_SRC_SZ:   r_src_size  <= i_cfg_data[25:0];
                p2f_pkg::CFG_SRC_PPR:  r_sppr      <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    // ready ripples back from the output: a stage loads when empty or draining
    assign w_rdy[NSTG] = !i_out_stall;
    for (genvar k = 0; k < NSTG; k++) begin : g_rdy
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
    end

    assign n_vld = {r_vld[NSTG-2:0], i_in_valid};

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_in_stall  = !w_rdy[0];
    assign o_out_valid = r_vld[P_OUT];
    assign o_out_word  = r_out;

    // center the coordinate, truncating toward zero
    always_comb begin
        w_kx = $signed({{(C_W-CB){1'b0}}, i_in_word.pano_x})
             - $signed({{(C_W-12){1'b0}}, r_pano_size[12:1]});
        w_ky = $signed({{(C_W-CB){1'b0}}, i_in_word.pano_y})
             - $signed({{(C_W-12){1'b0}}, r_pano_size[25:14]});
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[P_CTR]) begin
            r_cx <= (w_kx < 0) ? w_kx + C_W'(1) : w_kx;
            r_cy <= (w_ky < 0) ? w_ky + C_W'(1) : w_ky;
        end
    end

    // scale by radians per pixel
    always_ff @(posedge i_clk) begin
        if (w_rdy[P_MUL]) begin
            r_px_prd <= PRD_W'(r_cx) * PRD_W'($signed({1'b0, r_rpp}));
            r_py_prd <= PRD_W'(r_cy) * PRD_W'($signed({1'b0, r_rpp}));
        end
    end

    // bring Q.22 products to the angle format
    assign w_xe = TA_W'(r_px_prd);
    assign w_ye = TA_W'(r_py_prd);
    if (TA_SH > 0) begin : g_ta_rnd
        assign w_tax = (w_xe + $signed(TA_W'(64'd1 << (TA_SH - 1)))) >>> TA_SH;
        assign w_tay = (w_ye + $signed(TA_W'(64'd1 << (TA_SH - 1)))) >>> TA_SH;
    end else if (TA_SH == 0) begin : g_ta_same
        assign w_tax = w_xe;
        assign w_tay = w_ye;
    end else begin : g_ta_up
        assign w_tax = w_xe <<< (-TA_SH);
        assign w_tay = w_ye <<< (-TA_SH);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[P_ANG]) begin
            r_phi   <= sat_ang(w_tax);
            r_theta <= sat_ang(HALF_T - w_tay);
        end
    end

    // fold zenith and azimuth into the rotation range
    always_ff @(posedge i_clk) begin
        if (w_rdy[P_PRE1]) begin
            r_c1t <= sc_prep(Z_W'(r_theta), 1'b0);
            r_c1p <= sc_prep(Z_W'(r_phi), 1'b0);
        end
    end

    p2f_cordic_chain u_c1t (
        .i_clk  (i_clk),
        .i_en   (w_rdy[P_C1 +: NC]),
        .i_mode (p2f_pkg::MODE_ROT),
        .i_cord (r_c1t),
        .o_cord (w_o1t)
    );

    p2f_cordic_chain u_c1p (
        .i_clk  (i_clk),
        .i_en   (w_rdy[P_C1 +: NC]),
        .i_mode (p2f_pkg::MODE_ROT),
        .i_cord (r_c1p),
        .o_cord (w_o1p)
    );

    // undo the fold on cosines
    always_ff @(posedge i_clk) begin
        if (w_rdy[P_TRIG]) begin
            r_st <= T_W'(w_o1t.y);
            r_ct <= T_W'(w_o1t.side[0] ? -w_o1t.x : w_o1t.x);
            r_sp <= T_W'(w_o1p.y);
            r_cp <= T_W'(w_o1p.side[0] ? -w_o1p.x : w_o1p.x);
        end
    end

    // unit sphere vector
    always_ff @(posedge i_clk) begin
        if (w_rdy[P_VMUL]) begin
            r_psp <= PM_W'(r_st) * PM_W'(r_sp);
            r_pcp <= PM_W'(r_st) * PM_W'(r_cp);
            r_ct2 <= r_ct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[P_VEC]) begin
            r_v[0] <= T_W'(r_psp >>> 30);
            r_v[1] <= r_ct2;
            r_v[2] <= T_W'(r_pcp >>> 30);
        end
    end

    // matrix products
    always_ff @(posedge i_clk) begin
        if (w_rdy[P_MMUL]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_mp[i][j] <= MP_W'($signed(r_rot[i][47 - 16 * j -: 16]))
                                * MP_W'(r_v[j]);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_wsum[i] = MS_W'(r_mp[i][0]) + MS_W'(r_mp[i][1]) + MS_W'(r_mp[i][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[P_W]) begin
            for (int i = 0; i < 3; i++) begin
                r_w[i] <= XY_W'(w_wsum[i] >>> 14);
            end
        end
    end

    // flag the on-axis point and start the azimuth vectoring
    assign w_nz = (r_w[0] != '0) || (r_w[1] != '0);

    always_ff @(posedge i_clk) begin
        if (w_rdy[P_PRE2]) begin
            r_c2 <= vec_prep(r_w[0], r_w[1], SIDE_W'({w_nz, r_w[2]}));
        end
    end

    p2f_cordic_chain u_c2 (
        .i_clk  (i_clk),
        .i_en   (w_rdy[P_C2 +: NC]),
        .i_mode (p2f_pkg::MODE_VEC),
        .i_cord (r_c2),
        .o_cord (w_o2)
    );

    // remove CORDIC gain from the magnitude
    always_ff @(posedge i_clk) begin
        if (w_rdy[P_MAG1]) begin
            r_mg_prd <= MG_W'(w_o2.x >>> 8) * MG_W'(p2f_pkg::GAIN_Q30);
            r_psi1   <= w_o2.z;
            r_sd1    <= w_o2.side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[P_MAG2]) begin
            r_r    <= XY_W'(r_mg_prd >>> 22);
            r_psi2 <= r_psi1;
            r_sd2  <= r_sd1;
        end
    end

    // incident angle vectoring and azimuth sine/cosine run side by side
    always_ff @(posedge i_clk) begin
        if (w_rdy[P_PRE3]) begin
            r_c3v <= vec_prep(r_sd2[XY_W-1:0], r_r, '0);
            r_c3s <= sc_prep(r_psi2, r_sd2[XY_W]);
        end
    end

    p2f_cordic_chain u_c3v (
        .i_clk  (i_clk),
        .i_en   (w_rdy[P_C3 +: NC]),
        .i_mode (p2f_pkg::MODE_VEC),
        .i_cord (r_c3v),
        .o_cord (w_o3v)
    );

    p2f_cordic_chain u_c3s (
        .i_clk  (i_clk),
        .i_en   (w_rdy[P_C3 +: NC]),
        .i_mode (p2f_pkg::MODE_ROT),
        .i_cord (r_c3s),
        .o_cord (w_o3s)
    );

    // radius in source pixels
    always_ff @(posedge i_clk) begin
        if (w_rdy[P_RHO]) begin
            r_rho_prd <= RP_W'($signed({1'b0, r_sppr})) * RP_W'(w_o3v.z);
            r_c       <= T_W'(w_o3s.side[0] ? -w_o3s.x : w_o3s.x);
            r_s       <= T_W'(w_o3s.y);
            r_nz3     <= w_o3s.side[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[P_RHOS]) begin
            r_rho <= RHO_W'(r_rho_prd >>> AFB);
            r_c2b <= r_c;
            r_s2b <= r_s;
            r_nz4 <= r_nz3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[P_DMUL]) begin
            r_dxp <= DP_W'(r_rho) * DP_W'(r_c2b);
            r_dyp <= DP_W'(r_rho) * DP_W'(r_s2b);
            r_nz5 <= r_nz4;
        end
    end

    // offset by half the source size; zero the displacement on axis
    assign w_dx = r_nz5 ? (DP_W-30)'(r_dxp >>> 30) : '0;
    assign w_dy = r_nz5 ? (DP_W-30)'(r_dyp >>> 30) : '0;

    always_ff @(posedge i_clk) begin
        if (w_rdy[P_D]) begin
            r_sx <= SX_W'(w_dx) + $signed(SX_W'({r_src_size[12:1], 12'b0}));
            r_sy <= SX_W'(w_dy) + $signed(SX_W'({r_src_size[25:14], 12'b0}));
        end
    end

    // bounds check and output register
    assign w_ok = (r_sx > 0) && (r_sx < $signed(SX_W'({r_src_size[12:0], 12'b0})))
               && (r_sy > 0) && (r_sy < $signed(SX_W'({r_src_size[25:13], 12'b0})))
               && (r_sx[SX_W-1:12+CB] == '0) && (r_sy[SX_W-1:12+CB] == '0);

    always_ff @(posedge i_clk) begin
        if (w_rdy[P_OUT]) begin
            r_out.src_x     <= w_ok ? r_sx[12 +: CB] : '0;
            r_out.src_y     <= w_ok ? r_sy[12 +: CB] : '0;
            r_out.in_bounds <= w_ok;
        end
    end

    assign w_out_zero = (o_out_word.src_x == '0) && (o_out_word.src_y == '0);

    `P2F_ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, o_in_stall, &r_vld)
    `P2F_ASSERT_NEXT(a_take_fills, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_vld[P_CTR])
    `P2F_ASSERT_NEXT(a_ctr_moves, i_clk, i_rst_n, r_vld[P_CTR] && w_rdy[P_MUL], r_vld[P_MUL])
    `P2F_ASSERT_IMPL(a_black_zero, i_clk, i_rst_n, o_out_valid && !o_out_word.in_bounds, w_out_zero)

endmodule

`default_nettype wire

>>> sv/p2f_cordic_cell.sv
// One CORDIC micro-rotation cell with its output register.
// Depends on p2f_pkg for widths and the cell state type.
`default_nettype none

module p2f_cordic_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic                          i_mode,
    input  wire logic [p2f_pkg::SH_W-1:0]      i_shift,
    input  wire logic signed [p2f_pkg::Z_W-1:0] i_atan,
    input  wire p2f_pkg::t_cord                i_cord,
    output p2f_pkg::t_cord                     o_cord
);

    logic signed [p2f_pkg::XY_W-1:0] w_dx;
    logic signed [p2f_pkg::XY_W-1:0] w_dy;
    logic                            w_ccw;
    p2f_pkg::t_cord                  n_cord;
    p2f_pkg::t_cord                  r_cord;

    // pick direction: rotate toward zero angle, or vector toward zero y
    always_comb begin
        w_dx = $signed(i_cord.x) >>> i_shift;
        w_dy = $signed(i_cord.y) >>> i_shift;
        if (i_mode == p2f_pkg::MODE_VEC) begin
            w_ccw = i_cord.y[p2f_pkg::XY_W-1];
        end else begin
            w_ccw = !i_cord.z[p2f_pkg::Z_W-1];
        end
        n_cord.side = i_cord.side;
        if (w_ccw) begin
            n_cord.x = i_cord.x - w_dy;
            n_cord.y = i_cord.y + w_dx;
            n_cord.z = i_cord.z - i_atan;
        end else begin
            n_cord.x = i_cord.x + w_dy;
            n_cord.y = i_cord.y - w_dx;
            n_cord.z = i_cord.z + i_atan;
        end
    end

    // hold while the next stage is blocked
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cord <= n_cord;
        end
    end

    assign o_cord = r_cord;

endmodule

`default_nettype wire

>>> sv/p2f_cordic_chain.sv
// Row of CORDIC cells forming one lane; each cell shifts by its own index.
// Depends on p2f_pkg and p2f_cordic_cell.
`default_nettype none

module p2f_cordic_chain (
    input  wire logic                       i_clk,
    input  wire logic [p2f_pkg::NCELL-1:0]  i_en,
    input  wire logic                       i_mode,
    input  wire p2f_pkg::t_cord             i_cord,
    output p2f_pkg::t_cord                  o_cord
);

    p2f_pkg::t_cord w_link [p2f_pkg::NCELL+1];

    assign w_link[0] = i_cord;

    // one cell per micro-rotation
    for (genvar g = 0; g < p2f_pkg::NCELL; g++) begin : g_cell
        p2f_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (i_en[g]),
            .i_mode  (i_mode),
            .i_shift (p2f_pkg::SH_W'(g)),
            .i_atan  (p2f_pkg::atan_ang(g)),
            .i_cord  (w_link[g]),
            .o_cord  (w_link[g+1])
        );
    end

    assign o_cord = w_link[p2f_pkg::NCELL];

endmodule

`default_nettype wire
